// ----- sv/pkst_pkg.sv -----
// Package for the port-knock sequence tracker.
// Shared widths, register codes, reset values and the queued item type.
package pkst_pkg;

  localparam int SequenceStepsDefault = 3;
  localparam int ClientSlotsDefault   = 256;

  localparam int SlotW     = 8;
  localparam int PortW     = 16;
  localparam int ProgW     = 2;
  localparam int CfgIdxW   = 2;
  localparam int NumPorts  = 3;
  localparam int QueueDepth = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgPortOne   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPortTwo   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPortThree = 2'd2;

  // item modes
  localparam logic ModeKnock = 1'b0;
  localparam logic ModeCheck = 1'b1;

  localparam logic [PortW-1:0] PortResetVals [NumPorts] = '{
    16'd7777, 16'd5921, 16'd8675
  };

  // classified item, as it travels from front to back
  typedef struct packed {
    logic             mode;
    logic [SlotW-1:0] slot;
    logic             in_table;
    logic             matched;
    logic [ProgW-1:0] step;
  } pkst_item_t;

endpackage

// ----- sv/pkst_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pkst_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/pkst_front.sv -----
// Front end: holds the sequence port registers and classifies each knock.
// Depends on pkst_pkg.
module pkst_front #(
  parameter int SEQUENCE_STEPS = pkst_pkg::SequenceStepsDefault,
  parameter int CLIENT_SLOTS   = pkst_pkg::ClientSlotsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [pkst_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [pkst_pkg::PortW-1:0]  cfg_data_i,
  input  logic                        mode_i,
  input  logic [pkst_pkg::SlotW-1:0]  client_slot_i,
  input  logic [pkst_pkg::PortW-1:0]  dest_port_i,
  output pkst_pkg::pkst_item_t        item_o
);

  logic [pkst_pkg::PortW-1:0] ports_q [pkst_pkg::NumPorts];
  logic                       matched;
  logic [pkst_pkg::ProgW-1:0] step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ports_q <= pkst_pkg::PortResetVals;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        pkst_pkg::CfgPortOne:   ports_q[0] <= cfg_data_i;
        pkst_pkg::CfgPortTwo:   ports_q[1] <= cfg_data_i;
        pkst_pkg::CfgPortThree: ports_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // lowest matching step wins: scan from the top down
  always_comb begin
    matched = 1'b0;
    step    = '0;
    for (int k = SEQUENCE_STEPS - 1; k >= 0; k--) begin
      if (ports_q[k] == dest_port_i) begin
        matched = 1'b1;
        step    = pkst_pkg::ProgW'(k);
      end
    end
  end

  always_comb begin
    item_o.mode     = mode_i;
    item_o.slot     = client_slot_i;
    item_o.in_table = int'(client_slot_i) < CLIENT_SLOTS;
    item_o.matched  = matched;
    item_o.step     = step;
  end

endmodule

// ----- sv/pkst_queue.sv -----
// Short item queue between the classifier and the table sequencer.
// Depends on pkst_pkg.
module pkst_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  pkst_pkg::pkst_item_t item_i,
  input  logic                 pop_i,
  output pkst_pkg::pkst_item_t head_o,
  output logic                 empty_o,
  output logic                 full_o
);

  localparam int PtrW = $clog2(pkst_pkg::QueueDepth);
  localparam int CntW = $clog2(pkst_pkg::QueueDepth + 1);

  pkst_pkg::pkst_item_t store_q [pkst_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign empty_o = count_q == '0;
  assign full_o  = count_q == CntW'(pkst_pkg::QueueDepth);
  assign head_o  = store_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(pkst_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(pkst_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ----- sv/pkst_back.sv -----
// Back end: read-modify-write of the progress table and the result register.
// Depends on pkst_pkg; drives one pkst_ram instance from the top level.
module pkst_back #(
  parameter int SEQUENCE_STEPS = pkst_pkg::SequenceStepsDefault,
  parameter int TABLE_DEPTH    = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pkst_pkg::pkst_item_t           head_i,
  input  logic                           empty_i,
  output logic                           pop_o,
  output logic                           ram_re_o,
  output logic [$clog2(TABLE_DEPTH)-1:0] ram_raddr_o,
  input  logic [pkst_pkg::ProgW-1:0]     ram_rdata_i,
  output logic                           ram_we_o,
  output logic [$clog2(TABLE_DEPTH)-1:0] ram_waddr_o,
  output logic [pkst_pkg::ProgW-1:0]     ram_wdata_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [pkst_pkg::ProgW-1:0]     progress_o,
  output logic                           authorized_o,
  output logic                           port_matched_o
);

  localparam int AddrW = $clog2(TABLE_DEPTH);

  typedef enum logic {S_IDLE, S_CALC} state_e;

  state_e                     state_q;
  pkst_pkg::pkst_item_t       item_q;
  logic [TABLE_DEPTH-1:0]     valid_q;
  logic                       out_valid_q;
  logic [pkst_pkg::ProgW-1:0] progress_q;
  logic                       authorized_q;
  logic                       matched_q;

  logic [AddrW-1:0]           addr;
  logic [pkst_pkg::ProgW-1:0] prog_rd, new_prog;
  logic                       knock, commit;

  assign addr = item_q.slot[AddrW-1:0];

  always_comb begin
    pop_o       = (state_q == S_IDLE) && !empty_i;
    ram_re_o    = pop_o;
    ram_raddr_o = head_i.slot[AddrW-1:0];
    // entries never written read as zero; slots off the table too
    prog_rd  = (item_q.in_table && valid_q[addr]) ? ram_rdata_i : '0;
    knock    = (item_q.mode == pkst_pkg::ModeKnock) && item_q.matched;
    if (knock) begin
      new_prog = (prog_rd == item_q.step) ? prog_rd + 2'd1 : '0;
    end else begin
      new_prog = prog_rd;
    end
    commit      = (state_q == S_CALC) && (!out_valid_q || !out_stall_i);
    ram_we_o    = commit && knock && item_q.in_table;
    ram_waddr_o = addr;
    ram_wdata_o = new_prog;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      item_q       <= '0;
      valid_q      <= '0;
      out_valid_q  <= 1'b0;
      progress_q   <= '0;
      authorized_q <= 1'b0;
      matched_q    <= 1'b0;
    end else begin
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (pop_o) begin
            item_q  <= head_i;
            state_q <= S_CALC;
          end
        end
        S_CALC: begin
          if (commit) begin
            progress_q   <= new_prog;
            authorized_q <= new_prog == pkst_pkg::ProgW'(SEQUENCE_STEPS);
            matched_q    <= knock;
            state_q      <= S_IDLE;
            if (ram_we_o) begin
              valid_q[addr] <= 1'b1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign progress_o     = progress_q;
  assign authorized_o   = authorized_q;
  assign port_matched_o = matched_q;

  a_auth_means_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && authorized_q |-> progress_q == pkst_pkg::ProgW'(SEQUENCE_STEPS))
    else $error("authorized without full progress");

  a_prog_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> progress_q <= pkst_pkg::ProgW'(SEQUENCE_STEPS))
    else $error("progress beyond sequence length");

  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> state_q == S_IDLE && !empty_i)
    else $error("queue popped while busy");

  a_write_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |=> valid_q[$past(addr)] && out_valid_q)
    else $error("table write without valid mark or result");

endmodule

// ----- sv/port_knock_sequence_tracker.sv -----
// Port-knock sequence tracker, top level. Items (knock or check) are taken at
// up to one per cycle, while the queue is not full, into a two-item queue;
// the table sequencer then handles each item as a registered table read, then
// an update and write-back of the progress RAM, and pops no new item until it
// has committed the last one. The result is registered and held while the
// output is stalled. The progress table is cleared at reset through one valid
// flip-flop per entry; no clearing pass is needed.
// Depends on pkst_pkg, pkst_front, pkst_queue, pkst_back and pkst_ram.
module port_knock_sequence_tracker #(
  parameter int SEQUENCE_STEPS = pkst_pkg::SequenceStepsDefault,
  parameter int CLIENT_SLOTS   = pkst_pkg::ClientSlotsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pkst_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [pkst_pkg::PortW-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         mode_i,
  input  logic [pkst_pkg::SlotW-1:0]   client_slot_i,
  input  logic [pkst_pkg::PortW-1:0]   dest_port_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [pkst_pkg::ProgW-1:0]   progress_o,
  output logic                         authorized_o,
  output logic                         port_matched_o
);

  // slot field is 8 bits, so the table never needs more than 256 entries
  localparam int SlotSpan   = 1 << pkst_pkg::SlotW;
  localparam int TableDepth = (CLIENT_SLOTS > SlotSpan) ? SlotSpan : CLIENT_SLOTS;
  localparam int AddrW      = $clog2(TableDepth);

  pkst_pkg::pkst_item_t       front_item, head_item;
  logic                       push, pop, empty, full;
  logic                       ram_re, ram_we;
  logic [AddrW-1:0]           ram_raddr, ram_waddr;
  logic [pkst_pkg::ProgW-1:0] ram_rdata, ram_wdata;

  assign in_stall_o = full;
  assign push       = in_valid_i && !full;

  pkst_front #(
    .SEQUENCE_STEPS(SEQUENCE_STEPS),
    .CLIENT_SLOTS  (CLIENT_SLOTS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .mode_i       (mode_i),
    .client_slot_i(client_slot_i),
    .dest_port_i  (dest_port_i),
    .item_o       (front_item)
  );

  pkst_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (front_item),
    .pop_i  (pop),
    .head_o (head_item),
    .empty_o(empty),
    .full_o (full)
  );

  pkst_back #(
    .SEQUENCE_STEPS(SEQUENCE_STEPS),
    .TABLE_DEPTH   (TableDepth)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head_item),
    .empty_i       (empty),
    .pop_o         (pop),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .progress_o    (progress_o),
    .authorized_o  (authorized_o),
    .port_matched_o(port_matched_o)
  );

  pkst_ram #(
    .WIDTH(pkst_pkg::ProgW),
    .DEPTH(TableDepth)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench for port_knock_sequence_tracker: directed and random knock and check
// items, each result checked against a local model of the progress table.
// Depends on pkst_pkg and the tracker RTL.
module tb_top;

  localparam int Steps      = pkst_pkg::SequenceStepsDefault;
  localparam int Slots      = pkst_pkg::ClientSlotsDefault;
  localparam int StallLimit = 3000;
  localparam logic [pkst_pkg::CfgIdxW-1:0] CfgUnused = 2'd3;
  localparam logic [pkst_pkg::CfgIdxW-1:0] RegIdx [pkst_pkg::NumPorts] =
    '{pkst_pkg::CfgPortOne, pkst_pkg::CfgPortTwo, pkst_pkg::CfgPortThree};

  typedef struct packed {
    logic [pkst_pkg::ProgW-1:0] progress;
    logic                       authorized;
    logic                       matched;
  } knock_result_t;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         cfg_we_i      = 1'b0;
  logic [pkst_pkg::CfgIdxW-1:0] cfg_index_i   = '0;
  logic [pkst_pkg::PortW-1:0]   cfg_data_i    = '0;
  logic                         in_valid_i    = 1'b0;
  logic                         in_stall_o;
  logic                         mode_i        = pkst_pkg::ModeKnock;
  logic [pkst_pkg::SlotW-1:0]   client_slot_i = '0;
  logic [pkst_pkg::PortW-1:0]   dest_port_i   = '0;
  logic                         out_valid_o;
  logic                         out_stall_i   = 1'b0;
  logic [pkst_pkg::ProgW-1:0]   progress_o;
  logic                         authorized_o;
  logic                         port_matched_o;

  // local copy of the block's state
  logic [pkst_pkg::PortW-1:0] seq_ports [pkst_pkg::NumPorts];
  logic [pkst_pkg::ProgW-1:0] prog_tbl  [Slots];
  knock_result_t              expected_results [$];

  int errors      = 0;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int hold_left   = 0;
  int idle_cycles = 0;

  port_knock_sequence_tracker dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic knock_result_t knock_predict(logic mode,
                                                  logic [pkst_pkg::SlotW-1:0] slot,
                                                  logic [pkst_pkg::PortW-1:0] port);
    knock_result_t              res;
    logic [pkst_pkg::ProgW-1:0] prog;
    logic                       in_tbl;
    int                         step;
    in_tbl = int'(slot) < Slots;
    prog = in_tbl ? prog_tbl[slot] : '0;
    step = -1;
    res.matched = 1'b0;
    if (mode == pkst_pkg::ModeKnock) begin
      // descending scan so the lowest matching step wins
      for (int k = Steps - 1; k >= 0; k--) begin
        if (seq_ports[k] == port) step = k;
      end
      if (step >= 0) begin
        res.matched = 1'b1;
        prog = (int'(prog) == step) ? prog + 1'b1 : '0;
        if (in_tbl) prog_tbl[slot] = prog;
      end
    end
    res.progress = prog;
    res.authorized = int'(prog) == Steps;
    return res;
  endfunction

  task automatic check_field(string fname, logic [pkst_pkg::ProgW-1:0] want,
                             logic [pkst_pkg::ProgW-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
    end
  endtask

  // scoreboard: predict on input acceptance, compare on output acceptance
  always @(posedge clk_i) begin
    knock_result_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        expected_results.push_back(knock_predict(mode_i, client_slot_i, dest_port_i));
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got progress=%0d auth=%0b match=%0b",
                   $time, progress_o, authorized_o, port_matched_o);
        end else begin
          want = expected_results.pop_front();
          check_field("progress", want.progress, progress_o);
          check_field("authorized", pkst_pkg::ProgW'(want.authorized),
                      pkst_pkg::ProgW'(authorized_o));
          check_field("port_matched", pkst_pkg::ProgW'(want.matched),
                      pkst_pkg::ProgW'(port_matched_o));
        end
      end
    end
  end

  // receiver: random stall, or a long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= $urandom_range(99) < stall_pct;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else if (++idle_cycles >= StallLimit) begin
      $display("%0t: no handshake for %0d cycles", $time, StallLimit);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_item(logic mode, logic [pkst_pkg::SlotW-1:0] slot,
                           logic [pkst_pkg::PortW-1:0] port);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= mode;
    client_slot_i <= slot;
    dest_port_i   <= port;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // stop offering items and wait for every outstanding result
  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  // the unused index is poked too; it must leave the sequence alone
  task automatic write_ports(logic [pkst_pkg::PortW-1:0] p0, logic [pkst_pkg::PortW-1:0] p1,
                             logic [pkst_pkg::PortW-1:0] p2);
    logic [pkst_pkg::PortW-1:0] vals [pkst_pkg::NumPorts];
    vals = '{p0, p1, p2};
    drain;
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CfgUnused;
    cfg_data_i  <= pkst_pkg::PortW'($urandom);
    @(posedge clk_i);
    for (int k = 0; k < pkst_pkg::NumPorts; k++) begin
      cfg_index_i <= RegIdx[k];
      cfg_data_i  <= vals[k];
      @(posedge clk_i);
      seq_ports[k] = vals[k];
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // mostly the next step of the slot's sequence, some wrong steps, noise and checks
  task automatic send_random(int count);
    logic [pkst_pkg::SlotW-1:0] slot;
    logic [pkst_pkg::PortW-1:0] port;
    logic                       mode;
    int                         pick;
    repeat (count) begin
      pick = $urandom_range(99);
      slot = ($urandom_range(3) == 0) ? pkst_pkg::SlotW'($urandom)
                                      : pkst_pkg::SlotW'($urandom_range(7));
      mode = pkst_pkg::ModeKnock;
      if (pick < 12) begin
        mode = pkst_pkg::ModeCheck;
        port = pkst_pkg::PortW'($urandom);
      end else if (pick < 70) begin
        port = seq_ports[int'(prog_tbl[slot]) % Steps];
      end else if (pick < 85) begin
        port = seq_ports[$urandom_range(Steps - 1)];
      end else begin
        port = pkst_pkg::PortW'($urandom);
      end
      send_item(mode, slot, port);
    end
  endtask

  task automatic test_directed;
    send_item(pkst_pkg::ModeCheck, 8'd0, 16'd0);
    send_item(pkst_pkg::ModeKnock, 8'd0, seq_ports[0]);
    send_item(pkst_pkg::ModeKnock, 8'd0, seq_ports[1]);
    send_item(pkst_pkg::ModeCheck, 8'd0, 16'hFFFF);
    send_item(pkst_pkg::ModeKnock, 8'd0, seq_ports[2]);
    send_item(pkst_pkg::ModeCheck, 8'd0, 16'd0);
    send_item(pkst_pkg::ModeKnock, 8'd0, 16'd0);          // not in sequence: no change
    send_item(pkst_pkg::ModeKnock, 8'd0, seq_ports[0]);   // knock after completion resets
    send_item(pkst_pkg::ModeKnock, 8'd255, seq_ports[1]); // out of order
    send_item(pkst_pkg::ModeKnock, 8'd255, seq_ports[0]);
    send_item(pkst_pkg::ModeKnock, 8'd255, seq_ports[0]);
    send_item(pkst_pkg::ModeKnock, 8'd255, 16'hFFFF);
    send_item(pkst_pkg::ModeCheck, 8'd255, 16'hFFFF);
    // duplicate ports at the extremes: lowest step must win
    write_ports(16'h0000, 16'hFFFF, 16'h0000);
    send_item(pkst_pkg::ModeKnock, 8'd1, 16'h0000);
    send_item(pkst_pkg::ModeKnock, 8'd1, 16'hFFFF);
    send_item(pkst_pkg::ModeKnock, 8'd1, 16'h0000);
    write_ports(16'h1234, 16'h1234, 16'h1234);
    send_item(pkst_pkg::ModeKnock, 8'd2, 16'h1234);
    send_item(pkst_pkg::ModeKnock, 8'd2, 16'h1234);
    write_ports(pkst_pkg::PortResetVals[0], pkst_pkg::PortResetVals[1],
                pkst_pkg::PortResetVals[2]);
    send_item(pkst_pkg::ModeKnock, 8'd3, seq_ports[0]);
    send_item(pkst_pkg::ModeKnock, 8'd3, seq_ports[1]);
    send_item(pkst_pkg::ModeKnock, 8'd3, seq_ports[2]);
    send_item(pkst_pkg::ModeCheck, 8'd3, 16'h5A5A);
    drain;
  endtask

  // receiver holds off while items keep coming, so the input must stall
  task automatic test_backpressure;
    idle_pct  = 0;
    stall_pct = 0;
    hold_left = 300;
    send_random(40);
    drain;
  endtask

  task automatic test_random_phases;
    logic [pkst_pkg::PortW-1:0] dup;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct = 0;  stall_pct = 0;
          write_ports(pkst_pkg::PortW'($urandom), pkst_pkg::PortW'($urandom),
                      pkst_pkg::PortW'($urandom));
        end
        1: begin
          idle_pct = 55; stall_pct = 0;
          write_ports(16'h0000, 16'hFFFF, 16'h8000);
        end
        2: begin
          idle_pct = 0;  stall_pct = 55;
          dup = pkst_pkg::PortW'($urandom);
          write_ports(dup, dup, pkst_pkg::PortW'($urandom));
        end
        default: begin
          idle_pct = 27; stall_pct = 27;
          write_ports(pkst_pkg::PortW'($urandom), pkst_pkg::PortW'($urandom),
                      pkst_pkg::PortW'($urandom));
        end
      endcase
      send_random(400);
    end
    drain;
  endtask

  initial begin
    seq_ports = pkst_pkg::PortResetVals;
    foreach (prog_tbl[i]) prog_tbl[i] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed;
    test_backpressure;
    test_random_phases;
    stall_pct = 0;
    repeat (20) @(posedge clk_i);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0t: %0d mismatches, %0d results missing", $time, errors,
               expected_results.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/pkst_pkg.sv
sv/pkst_ram.sv
sv/pkst_front.sv
sv/pkst_queue.sv
sv/pkst_back.sv
sv/port_knock_sequence_tracker.sv
verif/tb_top.sv
